// ===== rtl/core/segint_pkg.sv =====
// shared types, constants and arithmetic helpers for the segment intersection block
`timescale 1ns / 1ps
package segint_pkg;

  localparam int CoordBits  = 32;
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;
  localparam int DenBits    = ProdBits + 1;
  localparam int TermBits   = 2 * CoordBits + 1;
  localparam int NumBits    = TermBits + DiffBits + 1;
  localparam int DivSteps   = CoordBits;
  localparam int RemBits    = (NumBits > DenBits + DivSteps) ? NumBits : DenBits + DivSteps;
  localparam int DivLatency = DivSteps + 2;

  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [DenBits-1:0]   den_t;
  typedef logic signed [TermBits-1:0]  term_t;
  typedef logic signed [NumBits-1:0]   num_t;
  typedef logic signed [CoordBits:0]   quot_t;

  typedef struct packed {
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t q1_x;
    coord_t q1_y;
    coord_t q2_x;
    coord_t q2_y;
  } seg_pair_t;

  typedef struct packed {
    logic [1:0] point_count;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
  } isect_t;

  // per-item control and early result that rides beside the divider
  typedef struct packed {
    logic       general;
    logic [1:0] count;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     x_lo;
    coord_t     x_hi;
    coord_t     y_lo;
    coord_t     y_hi;
  } side_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t mul_d(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic prod_t mul_c(coord_t a, coord_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/segint_chan.sv =====
// valid/ready channel interface carrying one word of a given type
`timescale 1ns / 1ps
interface segint_chan #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/segint_prep.sv =====
// front pipeline: bounding box, products, collinear overlap and the two numerators
`timescale 1ns / 1ps
module segint_prep
  import segint_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      in_valid,
  input  seg_pair_t pair_data,
  output logic      out_valid,
  output num_t      num_x,
  output num_t      num_y,
  output den_t      den,
  output side_t     side
);

  // stage 1: differences and box bounds
  logic      v1;
  seg_pair_t c1;
  diff_t     dx1_1, dy1_1, dx3_1, dy3_1, dx0_1, dy0_1, ecx_1, ecy_1;
  coord_t    xlo_1, xhi_1, ylo_1, yhi_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1    <= pair_data;
      dx1_1 <= sub_c(pair_data.p1_x, pair_data.p2_x);
      dy1_1 <= sub_c(pair_data.p1_y, pair_data.p2_y);
      dx3_1 <= sub_c(pair_data.q1_x, pair_data.q2_x);
      dy3_1 <= sub_c(pair_data.q1_y, pair_data.q2_y);
      dx0_1 <= sub_c(pair_data.q1_x, pair_data.p1_x);
      dy0_1 <= sub_c(pair_data.q1_y, pair_data.p1_y);
      ecx_1 <= sub_c(pair_data.q2_x, pair_data.p1_x);
      ecy_1 <= sub_c(pair_data.q2_y, pair_data.p1_y);
      xlo_1 <= cmax(cmin(pair_data.p1_x, pair_data.p2_x), cmin(pair_data.q1_x, pair_data.q2_x));
      xhi_1 <= cmin(cmax(pair_data.p1_x, pair_data.p2_x), cmax(pair_data.q1_x, pair_data.q2_x));
      ylo_1 <= cmax(cmin(pair_data.p1_y, pair_data.p2_y), cmin(pair_data.q1_y, pair_data.q2_y));
      yhi_1 <= cmin(cmax(pair_data.p1_y, pair_data.p2_y), cmax(pair_data.q1_y, pair_data.q2_y));
    end
  end

  // stage 2: all narrow products
  logic      v2, box_2;
  seg_pair_t c2;
  diff_t     dx1_2, dy1_2, dx3_2, dy3_2;
  coord_t    xlo_2, xhi_2, ylo_2, yhi_2;
  prod_t     mda_2, mdb_2, mca_2, mcb_2, mta_2, mtb_2, mua_2, mub_2;
  prod_t     sqx1_2, sqy1_2, sqx0_2, sqy0_2, sqxc_2, sqyc_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      box_2  <= (xlo_1 <= xhi_1) && (ylo_1 <= yhi_1);
      c2     <= c1;
      dx1_2  <= dx1_1;
      dy1_2  <= dy1_1;
      dx3_2  <= dx3_1;
      dy3_2  <= dy3_1;
      xlo_2  <= xlo_1;
      xhi_2  <= xhi_1;
      ylo_2  <= ylo_1;
      yhi_2  <= yhi_1;
      mda_2  <= mul_d(dx1_1, dy3_1);
      mdb_2  <= mul_d(dy1_1, dx3_1);
      mca_2  <= mul_d(dx0_1, dy3_1);
      mcb_2  <= mul_d(dy0_1, dx3_1);
      mta_2  <= mul_c(c1.p1_x, c1.p2_y);
      mtb_2  <= mul_c(c1.p1_y, c1.p2_x);
      mua_2  <= mul_c(c1.q1_x, c1.q2_y);
      mub_2  <= mul_c(c1.q1_y, c1.q2_x);
      sqx1_2 <= mul_d(dx1_1, dx1_1);
      sqy1_2 <= mul_d(dy1_1, dy1_1);
      sqx0_2 <= mul_d(dx0_1, dx0_1);
      sqy0_2 <= mul_d(dy0_1, dy0_1);
      sqxc_2 <= mul_d(ecx_1, ecx_1);
      sqyc_2 <= mul_d(ecy_1, ecy_1);
    end
  end

  // stage 3: denominator, determinants, squared distances
  logic      v3, box_3, col_3;
  seg_pair_t c3;
  diff_t     dx1_3, dy1_3, dx3_3, dy3_3;
  coord_t    xlo_3, xhi_3, ylo_3, yhi_3;
  den_t      den_3, dc2_3, d1_3, d2_3;
  term_t     t1_3, t2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      box_3 <= box_2;
      col_3 <= (mca_2 == mcb_2);
      c3    <= c2;
      dx1_3 <= dx1_2;
      dy1_3 <= dy1_2;
      dx3_3 <= dx3_2;
      dy3_3 <= dy3_2;
      xlo_3 <= xlo_2;
      xhi_3 <= xhi_2;
      ylo_3 <= ylo_2;
      yhi_3 <= yhi_2;
      den_3 <= den_t'(mda_2) - den_t'(mdb_2);
      t1_3  <= term_t'(mta_2) - term_t'(mtb_2);
      t2_3  <= term_t'(mua_2) - term_t'(mub_2);
      dc2_3 <= den_t'(sqx1_2) + den_t'(sqy1_2);
      d1_3  <= den_t'(sqx0_2) + den_t'(sqy0_2);
      d2_3  <= den_t'(sqxc_2) + den_t'(sqyc_2);
    end
  end

  // collinear overlap: ends picked by squared distance from p1
  logic       swap;
  den_t       dn, df;
  coord_t     ax, ay, bx, by;
  coord_t     r0x, r0y, r1x, r1y;
  logic       none_ovl;
  logic [1:0] col_cnt;
  side_t      side_c;

  always_comb begin
    swap     = d1_3 > d2_3;
    dn       = swap ? d2_3 : d1_3;
    df       = swap ? d1_3 : d2_3;
    ax       = swap ? c3.q2_x : c3.q1_x;
    ay       = swap ? c3.q2_y : c3.q1_y;
    bx       = swap ? c3.q1_x : c3.q2_x;
    by       = swap ? c3.q1_y : c3.q2_y;
    none_ovl = 1'b0;
    if (dn > '0) begin
      none_ovl = dc2_3 < dn;
      if (dc2_3 < df) begin
        r0x = c3.p2_x; r0y = c3.p2_y; r1x = ax; r1y = ay;
      end else begin
        r0x = ax; r0y = ay; r1x = bx; r1y = by;
      end
    end else begin
      r0x = c3.p1_x;
      r0y = c3.p1_y;
      if (dc2_3 < df) begin
        r1x = c3.p2_x; r1y = c3.p2_y;
      end else begin
        r1x = bx; r1y = by;
      end
    end
    col_cnt = ((r0x == r1x) && (r0y == r1y)) ? CountOne : CountTwo;

    side_c          = '0;
    side_c.general  = box_3 && (den_3 != '0);
    side_c.x_lo     = xlo_3;
    side_c.x_hi     = xhi_3;
    side_c.y_lo     = ylo_3;
    side_c.y_hi     = yhi_3;
    if (box_3 && (den_3 == '0) && col_3 && !none_ovl) begin
      side_c.count   = col_cnt;
      side_c.first_x = r0x;
      side_c.first_y = r0y;
      if (col_cnt == CountTwo) begin
        side_c.second_x = r1x;
        side_c.second_y = r1y;
      end
    end
  end

  // stage 4: numerator partial products, the 65-bit terms split at bit 32
  logic  v4;
  side_t side_4;
  den_t  den_4;
  prod_t pxl_4, pxh_4, qxl_4, qxh_4, pyl_4, pyh_4, qyl_4, qyh_4;
  diff_t t1lo, t1hi, t2lo, t2hi;

  assign t1lo = $signed({1'b0, t1_3[CoordBits-1:0]});
  assign t1hi = $signed(t1_3[TermBits-1:CoordBits]);
  assign t2lo = $signed({1'b0, t2_3[CoordBits-1:0]});
  assign t2hi = $signed(t2_3[TermBits-1:CoordBits]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_4 <= side_c;
      den_4  <= den_3;
      pxl_4  <= mul_d(t1lo, dx3_3);
      pxh_4  <= mul_d(t1hi, dx3_3);
      qxl_4  <= mul_d(t2lo, dx1_3);
      qxh_4  <= mul_d(t2hi, dx1_3);
      pyl_4  <= mul_d(t1lo, dy3_3);
      pyh_4  <= mul_d(t1hi, dy3_3);
      qyl_4  <= mul_d(t2lo, dy1_3);
      qyh_4  <= mul_d(t2hi, dy1_3);
    end
  end

  // stage 5: recombine partial products
  logic  v5;
  side_t side_5;
  den_t  den_5;
  num_t  ax_5, bx_5, ay_5, by_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_5 <= side_4;
      den_5  <= den_4;
      ax_5   <= (num_t'(pxh_4) <<< CoordBits) + num_t'(pxl_4);
      bx_5   <= (num_t'(qxh_4) <<< CoordBits) + num_t'(qxl_4);
      ay_5   <= (num_t'(pyh_4) <<< CoordBits) + num_t'(pyl_4);
      by_5   <= (num_t'(qyh_4) <<< CoordBits) + num_t'(qyl_4);
    end
  end

  // stage 6: final numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side  <= side_5;
      den   <= den_5;
      num_x <= ax_5 - bx_5;
      num_y <= ay_5 - by_5;
    end
  end

endmodule

// ===== rtl/core/segint_div.sv =====
// pipelined restoring signed divider, one quotient bit per stage, truncating toward zero
`timescale 1ns / 1ps
module segint_div
  import segint_pkg::*;
(
  input  logic  clk,
  input  logic  advance,
  input  num_t  num,
  input  den_t  den,
  output quot_t quot,
  output logic  ovf
);

  typedef logic [RemBits-1:0] rem_t;

  rem_t                rem [DivSteps+1];
  logic [DenBits-1:0]  dab [DivSteps+1];
  logic [DivSteps-1:0] qb  [DivSteps+1];
  logic                neg [DivSteps+1];
  logic                ov  [DivSteps+1];

  logic [NumBits-1:0] abs_n;
  logic [DenBits-1:0] abs_d;

  assign abs_n = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
  assign abs_d = den[DenBits-1] ? DenBits'(-den) : DenBits'(den);

  // magnitude and range check: quotient must fit in DivSteps bits
  always_ff @(posedge clk) begin
    if (advance) begin
      neg[0] <= num[NumBits-1] ^ den[DenBits-1];
      rem[0] <= rem_t'(abs_n);
      dab[0] <= abs_d;
      qb[0]  <= '0;
      ov[0]  <= rem_t'(abs_n) >= (rem_t'(abs_d) << DivSteps);
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int K = DivSteps - 1 - i;
    logic [RemBits:0]    trial;
    logic [DivSteps-1:0] qbit;

    assign trial = {1'b0, rem[i]} - ({1'b0, rem_t'(dab[i])} << K);
    assign qbit  = {{(DivSteps-1){1'b0}}, ~trial[RemBits]} << K;

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[i+1] <= trial[RemBits] ? rem[i] : trial[RemBits-1:0];
        qb[i+1]  <= qb[i] | qbit;
        dab[i+1] <= dab[i];
        neg[i+1] <= neg[i];
        ov[i+1]  <= ov[i];
      end
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (advance) begin
      quot <= neg[DivSteps] ? -quot_t'({1'b0, qb[DivSteps]}) : quot_t'({1'b0, qb[DivSteps]});
      ovf  <= ov[DivSteps];
    end
  end

endmodule

// ===== rtl/core/segment_pair_intersection_top.sv =====
// top level of the exact segment pair intersection pipeline
`timescale 1ns / 1ps
// Exact intersection of segment p1-p2 with segment q1-q2 on 32-bit signed
// coordinates, giving 0, 1 or 2 points per pair. A pair that passes the box
// test and has a nonzero cross-product denominator gets X and Y from the
// determinant formula through two pipelined restoring dividers; collinear
// overlaps are resolved in the front pipeline by squared distance from p1.
// One pair is taken every cycle unless the output stalls, and every pair yields
// exactly one result word. The path is six front stages, 34 divider stages (one
// quotient bit per stage, 32 bits, plus magnitude and sign stages) and the
// output register. All stages move together; when the output word is not
// taken the whole pipeline holds, so pair.ready follows result.ready.
module segment_pair_intersection_top
  import segint_pkg::*;
(
  input logic       clk,
  input logic       rst,
  segint_chan.sink   pair,
  segint_chan.source result
);

  // global pipeline enable: the output register is empty or being drained
  logic advance;

  assign advance    = !result.valid || result.ready;
  assign pair.ready = advance;

  // front pipeline
  logic  prep_valid;
  num_t  num_x, num_y;
  den_t  den;
  side_t prep_side;

  segint_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (pair.valid),
    .pair_data (pair.data),
    .out_valid (prep_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .side      (prep_side)
  );

  // one divider per axis, running in lockstep
  quot_t qx, qy;
  logic  ovf_x, ovf_y;

  segint_div u_div_x (
    .clk     (clk),
    .advance (advance),
    .num     (num_x),
    .den     (den),
    .quot    (qx),
    .ovf     (ovf_x)
  );

  segint_div u_div_y (
    .clk     (clk),
    .advance (advance),
    .num     (num_y),
    .den     (den),
    .quot    (qy),
    .ovf     (ovf_y)
  );

  // side info and valid bits delayed to match the divider latency
  side_t                 side_q [DivLatency];
  logic [DivLatency-1:0] side_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_v <= '0;
    end else if (advance) begin
      side_v <= {side_v[DivLatency-2:0], prep_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_q[0] <= prep_side;
      for (int i = 1; i < DivLatency; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // span test on the quotients and final word assembly
  side_t  sd;
  logic   x_ok, y_ok;
  isect_t word_next;

  assign sd = side_q[DivLatency-1];

  always_comb begin
    // inclusive at both ends of both segments on each axis
    x_ok = !ovf_x && (qx >= quot_t'(sd.x_lo)) && (qx <= quot_t'(sd.x_hi));
    y_ok = !ovf_y && (qy >= quot_t'(sd.y_lo)) && (qy <= quot_t'(sd.y_hi));
    word_next = '0;
    if (sd.general) begin
      if (x_ok && y_ok) begin
        word_next.point_count = CountOne;
        word_next.first_x     = qx[CoordBits-1:0];
        word_next.first_y     = qy[CoordBits-1:0];
      end
    end else begin
      // box reject, parallel lines or collinear overlap, settled up front
      word_next.point_count = sd.count;
      word_next.first_x     = sd.first_x;
      word_next.first_y     = sd.first_y;
      word_next.second_x    = sd.second_x;
      word_next.second_y    = sd.second_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= side_v[DivLatency-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.data <= word_next;
    end
  end

endmodule

// ===== rtl/core/segint_chk.sv =====
// port-level checker for the intersection block and its bind
`timescale 1ns / 1ps
module segint_chk
  import segint_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input isect_t out_data
);

  // a waiting word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.point_count != 2'd3)
    else $error("point count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.point_count == CountNone) |->
      out_data.first_x == '0 && out_data.first_y == '0 &&
      out_data.second_x == '0 && out_data.second_y == '0)
    else $error("unused points not zero");

  a_one_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.point_count == CountOne) |->
      out_data.second_x == '0 && out_data.second_y == '0)
    else $error("second point not zero for single point");

endmodule

bind segment_pair_intersection_top segint_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

// ===== test/segint_checker.sv =====
// scoreboard for the segment pair intersection block: predicts and compares result words
`timescale 1ns / 1ps
module segint_checker
  import segint_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pair_valid,
  input  logic      pair_ready,
  input  seg_pair_t pair_data,
  input  logic      result_valid,
  input  logic      result_ready,
  input  isect_t    result_data,
  output int        failures,
  output int        pending,
  output int        seen_none,
  output int        seen_one,
  output int        seen_two
);

  typedef logic signed [255:0] wide_t;

  isect_t expected_points[$];

  function automatic wide_t wmax(wide_t a, wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic wide_t wmin(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wide_t sq_dist(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
  endfunction

  function automatic bit spans(wide_t e1, wide_t e2, wide_t v);
    return (wmin(e1, e2) <= v) && (v <= wmax(e1, e2));
  endfunction

  function automatic isect_t intersect_pair(seg_pair_t s);
    wide_t ax, ay, bx, by, cx, cy, dx, dy;
    wide_t dx1, dy1, dx3, dy3, den, t1, t2, x, y;
    wide_t len2, near2, far2, nx, ny, fx, fy, r0, r1, r2, r3;
    isect_t res;
    res = '0;
    ax = s.p1_x; ay = s.p1_y; bx = s.p2_x; by = s.p2_y;
    cx = s.q1_x; cy = s.q1_y; dx = s.q2_x; dy = s.q2_y;
    // bounding boxes apart
    if (wmax(ax, bx) < wmin(cx, dx) || wmax(cx, dx) < wmin(ax, bx) ||
        wmax(ay, by) < wmin(cy, dy) || wmax(cy, dy) < wmin(ay, by))
      return res;
    dx1 = ax - bx; dy1 = ay - by;
    dx3 = cx - dx; dy3 = cy - dy;
    den = dx1 * dy3 - dy1 * dx3;
    if (den == 0) begin
      if ((cx - ax) * dy3 != (cy - ay) * dx3) return res;
      len2  = sq_dist(ax, ay, bx, by);
      near2 = sq_dist(ax, ay, cx, cy);
      far2  = sq_dist(ax, ay, dx, dy);
      if (near2 > far2) begin
        {near2, far2} = {far2, near2};
        nx = dx; ny = dy; fx = cx; fy = cy;
      end else begin
        nx = cx; ny = cy; fx = dx; fy = dy;
      end
      if (near2 > 0) begin
        if (len2 < near2) return res;
        if (len2 < far2) begin
          r0 = bx; r1 = by; r2 = nx; r3 = ny;
        end else begin
          r0 = nx; r1 = ny; r2 = fx; r3 = fy;
        end
      end else begin
        r0 = ax; r1 = ay;
        if (len2 < far2) begin
          r2 = bx; r3 = by;
        end else begin
          r2 = fx; r3 = fy;
        end
      end
      res.first_x = coord_t'(r0[31:0]);
      res.first_y = coord_t'(r1[31:0]);
      if (r0 == r2 && r1 == r3) begin
        res.point_count = CountOne;
      end else begin
        res.point_count = CountTwo;
        res.second_x = coord_t'(r2[31:0]);
        res.second_y = coord_t'(r3[31:0]);
      end
      return res;
    end
    t1 = ax * by - ay * bx;
    t2 = cx * dy - cy * dx;
    x = (t1 * dx3 - t2 * dx1) / den;
    if (!spans(ax, bx, x) || !spans(cx, dx, x)) return res;
    y = (t1 * dy3 - t2 * dy1) / den;
    if (!spans(ay, by, y) || !spans(cy, dy, y)) return res;
    res.point_count = CountOne;
    res.first_x = coord_t'(x[31:0]);
    res.first_y = coord_t'(y[31:0]);
    return res;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    isect_t exp_w;
    if (rst) begin
      failures  <= 0;
      seen_none <= 0;
      seen_one  <= 0;
      seen_two  <= 0;
    end else begin
      if (pair_valid && pair_ready) expected_points.push_back(intersect_pair(pair_data));
      if (result_valid && result_ready) begin
        if (expected_points.size() == 0) begin
          $error("result word with nothing expected: %p", result_data);
          failures <= failures + 1;
        end else begin
          exp_w = expected_points.pop_front();
          case (exp_w.point_count)
            CountNone: seen_none <= seen_none + 1;
            CountOne:  seen_one  <= seen_one + 1;
            default:   seen_two  <= seen_two + 1;
          endcase
          if (result_data !== exp_w) begin
            failures <= failures + 1;
            if (result_data.point_count !== exp_w.point_count)
              $error("point_count expected %0d got %0d", exp_w.point_count,
                     result_data.point_count);
            if (result_data.first_x !== exp_w.first_x)
              $error("first_x expected %0d got %0d", exp_w.first_x, result_data.first_x);
            if (result_data.first_y !== exp_w.first_y)
              $error("first_y expected %0d got %0d", exp_w.first_y, result_data.first_y);
            if (result_data.second_x !== exp_w.second_x)
              $error("second_x expected %0d got %0d", exp_w.second_x, result_data.second_x);
            if (result_data.second_y !== exp_w.second_y)
              $error("second_y expected %0d got %0d", exp_w.second_y, result_data.second_y);
          end
        end
      end
    end
  end

endmodule

// ===== test/segment_pair_intersection_top_test.sv =====
// stimulus, handshake pacing and verdict for the segment pair intersection block
`timescale 1ns / 1ps
module segment_pair_intersection_top_test
  import segint_pkg::*;
;

  localparam int RandomPairs = 2000;
  localparam int IdleLimit   = 4000;  // cycles with no word moving before we give up
  localparam int DrainCycles = 60;    // margin after the last expected result word arrives

  logic clk = 1'b0;
  logic rst = 1'b1;

  segint_chan #(.T(seg_pair_t)) pair_ch ();
  segint_chan #(.T(isect_t))    result_ch ();

  int failures, pending, seen_none, seen_one, seen_two;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  segment_pair_intersection_top DUT (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch)
  );

  segint_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_ch.valid),
    .pair_ready   (pair_ch.ready),
    .pair_data    (pair_ch.data),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_data  (result_ch.data),
    .failures     (failures),
    .pending      (pending),
    .seen_none    (seen_none),
    .seen_one     (seen_one),
    .seen_two     (seen_two)
  );

  // receiver side: stall at random at the current pressure, one change per falling edge
  initial result_ch.ready = 1'b0;
  always @(negedge clk) begin
    result_ch.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog: any cycle with no word moving counts toward the limit
  always @(posedge clk) begin
    if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("timeout: no traffic for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  // offer one pair, holding valid until the block takes it
  task automatic send_pair(seg_pair_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      pair_ch.valid = 1'b0;
      @(negedge clk);
    end
    pair_ch.valid = 1'b1;
    pair_ch.data  = s;
    do @(posedge clk); while (!pair_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic seg_pair_t make_pair(coord_t a, coord_t b, coord_t c, coord_t d,
                                          coord_t e, coord_t f, coord_t g, coord_t h);
    seg_pair_t s;
    s = {a, b, c, d, e, f, g, h};
    return s;
  endfunction

  // one coordinate of a given flavor: small, full range, extreme, or scaled small
  function automatic coord_t pick_coord(int flavor);
    int sh;
    case (flavor)
      0: return coord_t'($urandom_range(60)) - 30;
      1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return -1;
          4: return 32'sh7ffffffe;
          default: return 32'sh80000001;
        endcase
      end
      default: begin
        sh = $urandom_range(24);
        return (coord_t'($urandom_range(60)) - 30) <<< sh;
      end
    endcase
  endfunction

  // four points on one line: base plus multiples of a step, with random scale
  function automatic seg_pair_t collinear_pair();
    coord_t bx, by, sx, sy;
    int k[4];
    int sh;
    sh = $urandom_range(20);
    bx = (coord_t'($urandom_range(200)) - 100) <<< sh;
    by = (coord_t'($urandom_range(200)) - 100) <<< sh;
    sx = (coord_t'($urandom_range(8)) - 4) <<< sh;
    sy = (coord_t'($urandom_range(8)) - 4) <<< sh;
    foreach (k[i]) k[i] = $urandom_range(12) - 6;
    // sometimes share an endpoint so the overlap can collapse to a point
    if ($urandom_range(3) == 0) k[2] = k[$urandom_range(1)];
    return make_pair(bx + sx * k[0], by + sy * k[0], bx + sx * k[1], by + sy * k[1],
                     bx + sx * k[2], by + sy * k[2], bx + sx * k[3], by + sy * k[3]);
  endfunction

  function automatic seg_pair_t random_pair();
    int mode;
    int fl;
    seg_pair_t s;
    mode = $urandom_range(99);
    if (mode < 30) return collinear_pair();
    fl = (mode < 65) ? 0 : (mode < 80) ? 3 : (mode < 92) ? 1 : 2;
    s = make_pair(pick_coord(fl), pick_coord(fl), pick_coord(fl), pick_coord(fl),
                  pick_coord(fl), pick_coord(fl), pick_coord(fl), pick_coord(fl));
    // a few pairs draw q2_x from a randomly chosen flavor
    if (mode >= 97) s.q2_x = pick_coord($urandom_range(3));
    return s;
  endfunction

  localparam coord_t CMax = 32'sh7fffffff;
  localparam coord_t CMin = 32'sh80000000;

  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: crossings, touching, parallel, collinear and degenerate shapes, extremes
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));            // both segments one point
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));        // plain cross
    send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));            // cross off the lattice, truncated
    send_pair(make_pair(-7, 2, 5, -3, -6, -4, 4, 5));        // negative quotients
    send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));        // touching at an end
    send_pair(make_pair(0, 0, 10, 0, 11, -5, 11, 5));        // boxes apart in x
    send_pair(make_pair(0, 0, 0, 10, -5, 11, 5, 11));        // boxes apart in y
    send_pair(make_pair(0, 0, 10, 10, 5, 0, 10, 4));         // boxes overlap, point outside
    send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));          // parallel, apart
    send_pair(make_pair(0, 0, 10, 10, 2, 1, 12, 11));        // parallel, boxes overlap
    send_pair(make_pair(0, 0, 10, 0, 4, 0, 15, 0));          // collinear overlap
    send_pair(make_pair(0, 0, 10, 0, 15, 0, 4, 0));          // collinear, q reversed
    send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0));         // collinear, shared end
    send_pair(make_pair(0, 0, 10, 0, -3, 0, 5, 0));          // q straddles p1
    send_pair(make_pair(0, 0, 10, 0, 2, 0, 7, 0));           // q inside p
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));          // zero-length p on q
    send_pair(make_pair(0, 0, 10, 10, 4, 4, 4, 4));          // zero-length q on p
    send_pair(make_pair(0, 0, 10, 10, 4, 5, 4, 5));          // zero-length q off p
    send_pair(make_pair(CMin, CMin, CMax, CMax, CMin, CMax, CMax, CMin));
    send_pair(make_pair(CMax, CMin, CMin, CMax, CMax, CMin, CMin, CMax));
    send_pair(make_pair(CMin, CMin, CMax, CMin, CMin, CMin, CMax, CMin));
    send_pair(make_pair(CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax));
    send_pair(make_pair(-1, -1, CMax, 0, CMin, 0, 0, -1));
    send_pair(make_pair(CMin, 0, CMax, 1, 0, CMin, 1, CMax));

    // random part in four pacing phases
    for (int i = 0; i < RandomPairs; i++) begin
      case (i * 4 / RandomPairs)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      // short bursts with no idling inside every phase
      if ($urandom_range(9) == 0) sender_idle_pct = 0;
      send_pair(random_pair());
    end
    pair_ch.valid = 1'b0;
    receiver_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d segment pairs checked: %0d with no point, %0d with one, %0d overlaps",
             sent, seen_none, seen_one, seen_two);
    $display("pacing covered back-to-back, sparse sender, stalled receiver and mixed idling");
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/segint_pkg.sv
rtl/core/segint_chan.sv
rtl/core/segint_prep.sv
rtl/core/segint_div.sv
rtl/core/segment_pair_intersection_top.sv
rtl/core/segint_chk.sv
test/segint_checker.sv
test/segment_pair_intersection_top_test.sv
